// ----- hdl/obk_pkg.sv -----
// Shared codes and control types for the order book table.
package obk_pkg;

  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  localparam logic [2:0] ACT_CREATE = 3'd0;
  localparam logic [2:0] ACT_MODIFY = 3'd1;
  localparam logic [2:0] ACT_DELETE = 3'd2;
  localparam logic [2:0] ACT_BID    = 3'd3;
  localparam logic [2:0] ACT_ASK    = 3'd4;
  localparam logic [2:0] ACT_CLEAR  = 3'd5;

  localparam logic [1:0] TYPE_IOC = 2'd0;

  localparam logic [3:0] ST_CREATED    = 4'd0;
  localparam logic [3:0] ST_IOC        = 4'd1;
  localparam logic [3:0] ST_ID_EXISTS  = 4'd2;
  localparam logic [3:0] ST_AMENDED    = 4'd3;
  localparam logic [3:0] ST_MOD_MISS   = 4'd4;
  localparam logic [3:0] ST_PRICE_DIFF = 4'd5;
  localparam logic [3:0] ST_QTY_HIGH   = 4'd6;
  localparam logic [3:0] ST_DELETED    = 4'd7;
  localparam logic [3:0] ST_DEL_MISS   = 4'd8;
  localparam logic [3:0] ST_BEST       = 4'd9;
  localparam logic [3:0] ST_EMPTY      = 4'd10;
  localparam logic [3:0] ST_CLEARED    = 4'd11;
  localparam logic [3:0] ST_FULL       = 4'd12;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } obk_cmd_t;

  typedef struct packed {
    logic req_ok;
    logic scan_done;
  } obk_stat_t;

endpackage

// ----- hdl/obk_ctrl.sv -----
// Sequencer for one operation: load, table scan, commit, result hold.
module obk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  obk_pkg::obk_stat_t stat,
  output obk_pkg::obk_cmd_t  cmd
);
  import obk_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.scan   = (state == S_SCAN) && stat.req_ok;
    cmd.finish = (state == S_FINISH) && !(out_valid && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SCAN;
        end
        S_SCAN: begin
          // drop unused action codes without a result
          if (!stat.req_ok) state <= S_IDLE;
          else if (stat.scan_done) state <= S_FINISH;
        end
        S_FINISH: begin
          if (cmd.finish) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/obk_dp.sv -----
// Order table storage, scan compare stage and result registers.
module obk_dp #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  obk_pkg::obk_cmd_t         cmd,
  output obk_pkg::obk_stat_t        stat,
  input  logic [2:0]                action,
  input  logic                      is_bid,
  input  logic [31:0]               order_id,
  input  logic [31:0]               price,
  input  logic [31:0]               quantity,
  input  logic [1:0]                order_type,
  output logic [3:0]                status,
  output logic [31:0]               best_price,
  output logic [obk_pkg::CNT_W-1:0] bids_cleared,
  output logic [obk_pkg::CNT_W-1:0] asks_cleared
);
  import obk_pkg::*;

  localparam int IW = $clog2(TABLE_ENTRIES);

  logic [31:0] mem_id    [TABLE_ENTRIES];
  logic [31:0] mem_price [TABLE_ENTRIES];
  logic [31:0] mem_qty   [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid;
  logic [TABLE_ENTRIES-1:0] side;

  logic [2:0]  r_act;
  logic        r_side;
  logic [31:0] r_id, r_price, r_qty;
  logic [1:0]  r_type;

  logic [IW:0]   rd_cnt;
  logic          p_vld, p_ent, p_side;
  logic [IW-1:0] p_idx;
  logic [31:0]   q_id, q_price, q_qty;

  logic          hit, free_f, bhit, ahit, bf;
  logic [IW-1:0] hit_idx, free_idx, bhit_idx, ahit_idx;
  logic [31:0]   hit_price, hit_qty, best;
  logic [CNT_W-1:0] nb, na;

  logic issue, id_eq, want;
  assign issue = cmd.scan && (rd_cnt < (IW+1)'(TABLE_ENTRIES));
  assign id_eq = (q_id == r_id);
  assign want  = (r_act == ACT_BID);

  assign stat.req_ok    = (r_act <= ACT_CLEAR);
  assign stat.scan_done = (rd_cnt == (IW+1)'(TABLE_ENTRIES)) && !p_vld;

  // table read port, one entry a cycle
  always_ff @(posedge clk) begin
    if (issue) begin
      q_id    <= mem_id[rd_cnt[IW-1:0]];
      q_price <= mem_price[rd_cnt[IW-1:0]];
      q_qty   <= mem_qty[rd_cnt[IW-1:0]];
      p_ent   <= valid[rd_cnt[IW-1:0]];
      p_side  <= side[rd_cnt[IW-1:0]];
      p_idx   <= rd_cnt[IW-1:0];
    end
  end

  // table write port
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (r_act == ACT_CREATE && r_type != TYPE_IOC && !hit && free_f) begin
        mem_id[free_idx]    <= r_id;
        mem_price[free_idx] <= r_price;
        mem_qty[free_idx]   <= r_qty;
      end else if (r_act == ACT_MODIFY && hit && hit_price == r_price && hit_qty > r_qty) begin
        mem_qty[hit_idx] <= r_qty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_cnt <= '0;
      p_vld  <= 1'b0;
      r_act  <= ACT_CREATE;
    end else begin
      p_vld <= issue;
      if (issue) rd_cnt <= rd_cnt + 1'b1;
      if (cmd.load) begin
        r_act   <= action;
        r_side  <= is_bid;
        r_id    <= order_id;
        r_price <= price;
        r_qty   <= quantity;
        r_type  <= order_type;
        rd_cnt  <= '0;
        hit     <= 1'b0;
        free_f  <= 1'b0;
        bhit    <= 1'b0;
        ahit    <= 1'b0;
        bf      <= 1'b0;
        best    <= '0;
        nb      <= '0;
        na      <= '0;
      end
      if (p_vld) begin
        if (p_ent && p_side == r_side && id_eq && !hit) begin
          hit       <= 1'b1;
          hit_idx   <= p_idx;
          hit_price <= q_price;
          hit_qty   <= q_qty;
        end
        if (!p_ent && !free_f) begin
          free_f   <= 1'b1;
          free_idx <= p_idx;
        end
        if (p_ent && p_side && id_eq && !bhit) begin
          bhit     <= 1'b1;
          bhit_idx <= p_idx;
        end
        if (p_ent && !p_side && id_eq && !ahit) begin
          ahit     <= 1'b1;
          ahit_idx <= p_idx;
        end
        if (p_ent && p_side == want) begin
          if (!bf || (want ? (q_price > best) : (q_price < best))) best <= q_price;
          bf <= 1'b1;
        end
        if (p_ent) begin
          if (p_side) begin
            if (nb != CNT_MAX) nb <= nb + 1'b1;
          end else begin
            if (na != CNT_MAX) na <= na + 1'b1;
          end
        end
      end
      if (cmd.finish) begin
        status       <= ST_CREATED;
        best_price   <= '0;
        bids_cleared <= '0;
        asks_cleared <= '0;
        case (r_act)
          ACT_CREATE: begin
            if (r_type == TYPE_IOC) status <= ST_IOC;
            else if (hit) status <= ST_ID_EXISTS;
            else if (!free_f) status <= ST_FULL;
            else begin
              valid[free_idx] <= 1'b1;
              side[free_idx]  <= r_side;
            end
          end
          ACT_MODIFY: begin
            if (!hit) status <= ST_MOD_MISS;
            else if (hit_price != r_price) status <= ST_PRICE_DIFF;
            else if (hit_qty <= r_qty) status <= ST_QTY_HIGH;
            else status <= ST_AMENDED;
          end
          ACT_DELETE: begin
            if (bhit) begin
              valid[bhit_idx] <= 1'b0;
              status <= ST_DELETED;
            end else if (ahit) begin
              valid[ahit_idx] <= 1'b0;
              status <= ST_DELETED;
            end else status <= ST_DEL_MISS;
          end
          ACT_BID, ACT_ASK: begin
            status     <= bf ? ST_BEST : ST_EMPTY;
            best_price <= bf ? best : 32'd0;
          end
          ACT_CLEAR: begin
            valid        <= '0;
            status       <= ST_CLEARED;
            bids_cleared <= nb;
            asks_cleared <= na;
          end
          default: status <= ST_CREATED;
        endcase
      end
    end
  end
endmodule

// ----- hdl/order_book_table.sv -----
// Order book table: scans all entries once per defined operation, one entry a cycle.
// Each accepted beat is loaded, walked through the table read port and compare
// stage, then committed to the result registers; a new beat is taken only once
// the last is committed. Unused action codes are dropped without a result beat.
// Reset empties the table at once through per-entry valid flops.
module order_book_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic        is_bid,
  input  logic [31:0] order_id,
  input  logic [31:0] price,
  input  logic [31:0] quantity,
  input  logic [1:0]  order_type,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [31:0] best_price,
  output logic [6:0]  bids_cleared,
  output logic [6:0]  asks_cleared
);
  import obk_pkg::*;

  obk_cmd_t  cmd;
  obk_stat_t stat;

  obk_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .stat(stat), .cmd(cmd)
  );

  obk_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .action(action), .is_bid(is_bid), .order_id(order_id), .price(price),
    .quantity(quantity), .order_type(order_type), .status(status),
    .best_price(best_price), .bids_cleared(bids_cleared),
    .asks_cleared(asks_cleared)
  );
endmodule
